// File: sv/met_pkg.sv
// Shared types and constants for the fixed-point escape-time evaluator.
package met_pkg;

  localparam int unsigned CoordW       = 17;
  localparam int unsigned CountW       = 8;
  localparam logic [7:0]  MaxIterReset = 8'd127;
  localparam int unsigned EscRadiusSq  = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AA,
    ST_BB,
    ST_AB,
    ST_DONE
  } met_state_e;

  typedef enum logic [1:0] {
    MS_AA,
    MS_BB,
    MS_AB
  } met_mul_sel_e;

  typedef struct packed {
    logic         load;
    met_mul_sel_e mul_sel;
    logic         cap_aa;
    logic         cap_bb;
    logic         step;
    logic         finish;
  } met_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic budget_zero;
    logic esc;
    logic cnt_last;
    logic out_free;
  } met_stat_t;

endpackage

// File: sv/met_mul.sv
// Shared signed multiplier with operand selection for z_re^2, z_im^2 and z_re*z_im.
module met_mul #(
  parameter int unsigned ZW = 19
) (
  input  logic signed [ZW-1:0]   zre_i,
  input  logic signed [ZW-1:0]   zim_i,
  input  met_pkg::met_mul_sel_e  sel_i,
  output logic signed [2*ZW-1:0] prod_o
);
  import met_pkg::*;

  logic signed [ZW-1:0] op_a;
  logic signed [ZW-1:0] op_b;

  always_comb begin
    case (sel_i)
      MS_AA: begin
        op_a = zre_i;
        op_b = zre_i;
      end
      MS_BB: begin
        op_a = zim_i;
        op_b = zim_i;
      end
      MS_AB: begin
        op_a = zre_i;
        op_b = zim_i;
      end
      default: begin
        op_a = zre_i;
        op_b = zre_i;
      end
    endcase
  end

  assign prod_o = op_a * op_b;

endmodule

// File: sv/met_ctrl.sv
// Sequencer that steps the shared multiplier through each iteration.
module met_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  met_pkg::met_stat_t stat_i,
  output met_pkg::met_ctrl_t ctrl_o,
  output logic              idle_o
);
  import met_pkg::*;

  met_state_e state_q;
  met_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) begin
          state_d = stat_i.budget_zero ? ST_DONE : ST_AA;
        end
      end
      ST_AA: state_d = ST_BB;
      ST_BB: state_d = ST_AB;
      ST_AB: begin
        if (stat_i.esc || stat_i.cnt_last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_AA;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_sel = MS_AA;
    idle_o         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idle_o      = 1'b1;
        ctrl_o.load = stat_i.in_valid;
      end
      ST_AA: begin
        ctrl_o.mul_sel = MS_AA;
        ctrl_o.cap_aa  = 1'b1;
      end
      ST_BB: begin
        ctrl_o.mul_sel = MS_BB;
        ctrl_o.cap_bb  = 1'b1;
      end
      ST_AB: begin
        ctrl_o.mul_sel = MS_AB;
        ctrl_o.step    = !stat_i.esc;
      end
      ST_DONE: begin
        ctrl_o.finish = stat_i.out_free;
      end
      default: begin
        idle_o = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/mandelbrot_escape_time.sv
// Top level of the fixed-point escape-time evaluator: datapath, config and result register.
// Throughput: one point at a time; the shared multiplier runs three products per iteration.
// The input side is ready only while idle; a held result holds the next point in ST_DONE.
// Reset (rst_ni low, asynchronous) returns to idle, drops any result and sets max_iter to 127.
module mandelbrot_escape_time #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [met_pkg::CountW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [met_pkg::CoordW-1:0] c_re_i,
  input  logic signed [met_pkg::CoordW-1:0] c_im_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [met_pkg::CountW-1:0]    remaining_count_o
);
  import met_pkg::*;

  localparam int unsigned ZW = ((FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16) + 3;
  localparam int unsigned PW = 2 * ZW;
  localparam int unsigned AW = PW - FRAC_BITS;
  localparam logic [AW:0] Limit = (AW + 1)'(EscRadiusSq) << FRAC_BITS;

  logic [CountW-1:0]      max_iter_q;
  logic signed [ZW-1:0]   zre_q, zre_d;
  logic signed [ZW-1:0]   zim_q, zim_d;
  logic signed [ZW-1:0]   cre_q;
  logic signed [ZW-1:0]   cim_q;
  logic [AW-1:0]          aa_q;
  logic [AW-1:0]          bb_q;
  logic [CountW-1:0]      count_q;
  logic [CountW-1:0]      res_q;
  logic                   out_valid_q;
  logic signed [PW-1:0]   prod;
  logic [AW:0]            mag_sq;
  logic signed [ZW-1:0]   cre_ext;
  logic signed [ZW-1:0]   cim_ext;
  logic                   idle;
  met_ctrl_t              ctrl;
  met_stat_t              stat;

  assign cre_ext = {{(ZW - CoordW){c_re_i[CoordW-1]}}, c_re_i};
  assign cim_ext = {{(ZW - CoordW){c_im_i[CoordW-1]}}, c_im_i};

  met_mul #(
    .ZW(ZW)
  ) u_mul (
    .zre_i  (zre_q),
    .zim_i  (zim_q),
    .sel_i  (ctrl.mul_sel),
    .prod_o (prod)
  );

  assign mag_sq = {1'b0, aa_q} + {1'b0, bb_q};

  assign stat.in_valid    = in_valid_i;
  assign stat.budget_zero = (max_iter_q == '0);
  assign stat.esc         = (mag_sq > Limit);
  assign stat.cnt_last    = (count_q == CountW'(1));
  assign stat.out_free    = !out_valid_q || out_ready_i;

  met_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .idle_o (idle)
  );

  assign zim_d = $signed(prod[FRAC_BITS+ZW-2:FRAC_BITS-1]) + cim_q;
  assign zre_d = $signed(aa_q[ZW-1:0]) - $signed(bb_q[ZW-1:0]) + cre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterReset;
    end else if (cfg_we_i) begin
      max_iter_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      zre_q   <= cre_ext;
      zim_q   <= cim_ext;
      cre_q   <= cre_ext;
      cim_q   <= cim_ext;
      count_q <= max_iter_q;
    end else if (ctrl.step) begin
      zre_q   <= zre_d;
      zim_q   <= zim_d;
      count_q <= count_q - CountW'(1);
    end
    if (ctrl.cap_aa) begin
      aa_q <= prod[PW-1:FRAC_BITS];
    end
    if (ctrl.cap_bb) begin
      bb_q <= prod[PW-1:FRAC_BITS];
    end
    if (ctrl.finish) begin
      res_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o        = idle;
  assign out_valid_o       = out_valid_q;
  assign remaining_count_o = res_q;

endmodule

// File: verif/mandelbrot_escape_time_tb.sv
// Self-checking testbench for the fixed-point escape-time evaluator.
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb;
  import met_pkg::*;

  localparam int FracBits = 14;
  localparam int NumPhases = 9;
  localparam int HoldCycles = 400;
  localparam int MaxGap = 12;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CountW-1:0] count_t;

  class escape_scoreboard;
    typedef struct {
      coord_t c_re;
      coord_t c_im;
      count_t count;
    } point_t;

    point_t expected_counts[$];
    count_t budget = MaxIterReset;
    int unsigned checked;
    int unsigned bounded;
    int unsigned mismatches;

    function void set_budget(count_t value);
      budget = value;
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction

    function count_t escape_count(coord_t cre, coord_t cim);
      longint re;
      longint im;
      longint zaa;
      longint zbb;
      longint radius_sq;
      count_t cnt;
      re = cre;
      im = cim;
      radius_sq = longint'(EscRadiusSq) << FracBits;
      cnt = budget;
      while (cnt != 0) begin
        zaa = (re * re) >>> FracBits;
        zbb = (im * im) >>> FracBits;
        if (zaa + zbb > radius_sq) break;
        im = ((re * im * 2) >>> FracBits) + longint'(cim);
        re = zaa - zbb + longint'(cre);
        cnt--;
      end
      return cnt;
    endfunction

    function void note_point(coord_t cre, coord_t cim);
      point_t pt;
      pt.c_re = cre;
      pt.c_im = cim;
      pt.count = escape_count(cre, cim);
      expected_counts.push_back(pt);
    endfunction

    function void check_count(count_t actual);
      point_t pt;
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("remaining_count %0d arrived with no point outstanding", actual);
        return;
      end
      pt = expected_counts.pop_front();
      checked++;
      if (pt.count == 0) bounded++;
      if (actual !== pt.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("remaining_count mismatch for c=(%0d,%0d) budget %0d: expected %0d got %0d",
                   pt.c_re, pt.c_im, budget, pt.count, actual);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  count_t cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  coord_t c_re_i;
  coord_t c_im_i;
  logic out_valid_o;
  logic out_ready_i;
  count_t remaining_count_o;

  escape_scoreboard sb = new();
  logic steady = 1'b0;
  logic hold_requested = 1'b0;
  logic hold_served = 1'b0;
  longint cycle_limit = 64'd4000000;
  longint cycle_count = 0;

  int dir_re[15] = '{0, -65536, 65535, -32768, 0, -16384, -65536, 65535, 32768,
                     0, 32769, 4096, -12288, -1, -29491};
  int dir_im[15] = '{0, -65536, 65535, 0, 16384, 0, 65535, -65536, 0,
                     32768, 0, 0, 1638, -1, 0};

  mandelbrot_escape_time #(
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .c_re_i           (c_re_i),
    .c_im_i           (c_im_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .remaining_count_o(remaining_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_point(c_re_i, c_im_i);
      if (out_valid_o && out_ready_i) sb.check_count(remaining_count_o);
    end
  end

  initial begin
    while (cycle_count < cycle_limit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_requested && !hold_served) begin
        stall = HoldCycles;
        hold_served = 1'b1;
      end else begin
        stall = steady ? 0 : $urandom_range(0, MaxGap);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic void pick_point(output coord_t re, output coord_t im);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 55) begin
      re = coord_t'(int'($urandom_range(0, 44236)) - 34406);
      im = coord_t'(int'($urandom_range(0, 42598)) - 21299);
    end else if (mode < 65) begin
      re = coord_t'(int'($urandom_range(0, 65535)) - 32768);
      im = coord_t'(int'($urandom_range(0, 65535)) - 32768);
    end else if (mode < 95) begin
      re = coord_t'($urandom);
      im = coord_t'($urandom);
    end else begin
      re = ($urandom_range(0, 1) != 0) ? coord_t'(-65536) : coord_t'(65535);
      im = ($urandom_range(0, 1) != 0) ? coord_t'(-1) : coord_t'(0);
    end
  endfunction

  task automatic send_point(input coord_t re, input coord_t im);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    c_re_i <= re;
    c_im_i <= im;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain(input int unsigned settle);
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_budget(input count_t value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_budget(value);
  endtask

  initial begin
    int unsigned budgets[NumPhases];
    int unsigned counts[NumPhases];
    int unsigned num_directed;
    int unsigned sent;
    longint bound;
    coord_t re;
    coord_t im;
    budgets = '{127, 0, 1, 255, 16, 7, 64, 0, 32};
    counts = '{100, 40, 100, 60, 180, 150, 120, 80, 70};
    budgets[7] = $urandom_range(2, 100);
    bound = 20000;
    foreach (budgets[p])
      bound += longint'(counts[p] + 15) * (3 * budgets[p] + 2 + 2 * (MaxGap + 1) + 10);
    cycle_limit = 4 * (bound + HoldCycles);
    sent = 0;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    c_re_i <= '0;
    c_im_i <= '0;
    out_ready_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        in_valid_i <= 1'b0;
        drain(3 * budgets[p - 1] + 10);
        write_budget(count_t'(budgets[p]));
      end
      num_directed = (p == 0) ? 15 : (p == 1) ? 3 : (p == 3) ? 6 : 0;
      for (int d = 0; d < num_directed; d++)
        send_point(coord_t'(dir_re[d]), coord_t'(dir_im[d]));
      for (int n = 0; n < counts[p]; n++) begin
        if (sent % 40 == 0) steady = ($urandom_range(0, 2) == 0);
        if (p == 5 && n == 30) hold_requested = 1'b1;
        pick_point(re, im);
        send_point(re, im);
        sent++;
      end
    end
    in_valid_i <= 1'b0;
    drain(3 * budgets[NumPhases - 1] + 10);

    $display("Checked %0d escape counts over %0d iteration budgets, 0, 1 and 255 among them.",
             sb.checked, NumPhases);
    $display("%0d points stayed bounded; results were held off %0d cycles once to back up input.",
             sb.bounded, HoldCycles);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
